[rtl/pctbl_pkg.sv]
// Shared types and constants for the per-client token bucket limiter.
package pctbl_pkg;

  localparam int BUCKETS      = 256;
  localparam int IDX_W        = $clog2(BUCKETS);
  localparam int TIME_W       = 48;
  localparam int TOK_W        = 16;
  localparam int PERIOD_W     = 32;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 32;
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 24;
  localparam int DIV_STEPS    = TIME_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [TOK_W-1:0]    TOKEN_MAX_RST = 16'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 32'd1000;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TOKEN_MAX = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD    = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_CLAMP,
    ST_WRITE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic clamp;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

[rtl/pctbl_ctrl.sv]
// Controller state machine sequencing one request through the datapath.
module pctbl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  pctbl_pkg::status_t status,
  output pctbl_pkg::cmd_t    cmd
);
  import pctbl_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        // Hold until the output register can take the result word
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/pctbl_dp.sv]
// Datapath: config registers, bucket store, serial divider, refill and output register.
module pctbl_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pctbl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pctbl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [pctbl_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pctbl_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  pctbl_pkg::cmd_t                     cmd,
  output pctbl_pkg::status_t                  status
);
  import pctbl_pkg::*;

  // Configuration
  logic [TOK_W-1:0]    token_max;
  logic [PERIOD_W-1:0] period;

  // Bucket store
  logic [BUCKETS-1:0]  bucket_valid;
  logic [TOK_W-1:0]    mem_tok  [BUCKETS];
  logic [TIME_W-1:0]   mem_last [BUCKETS];
  logic [TOK_W-1:0]    rd_tok;
  logic [TIME_W-1:0]   rd_last;

  // Request context
  logic [IDX_W-1:0]    idx;
  logic [TIME_W-1:0]   now;
  logic                vld;
  logic                later;

  // Divider
  logic [TIME_W-1:0]    dq;
  logic [PERIOD_W-1:0]  rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PERIOD_W:0]    shifted;
  logic [PERIOD_W+1:0]  trial;
  logic                 qbit;

  // Refill and take
  logic [TOK_W-1:0]    level;
  logic [TIME_W-1:0]   earned;
  logic [TOK_W-1:0]    base;
  logic [TOK_W:0]      sum;
  logic                over;
  logic                allow;
  logic [TOK_W-1:0]    tok_new;
  logic [TIME_W:0]     diff;

  // Output register payload
  logic                out_allowed;
  logic [TOK_W-1:0]    out_tokens;
  logic                out_created;

  // Control state: config, valid marks, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      token_max    <= TOKEN_MAX_RST;
      period       <= PERIOD_RST;
      bucket_valid <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TOKEN_MAX: token_max <= cfg_wdata[TOK_W-1:0];
          REG_PERIOD:    period    <= cfg_wdata[PERIOD_W-1:0];
          default:       ;
        endcase
      end
      if (cmd.finish) begin
        bucket_valid[idx] <= 1'b1;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Bucket memory: registered read on accept, write on finish
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_tok  <= mem_tok[s_tdata[IDX_W-1:0]];
      rd_last <= mem_last[s_tdata[IDX_W-1:0]];
    end
    if (cmd.finish) begin
      mem_tok[idx] <= tok_new;
      if (allow || !vld) begin
        mem_last[idx] <= now;
      end
    end
  end

  // Elapsed time and one restoring divide step
  always_comb begin
    diff    = {1'b0, now} - {1'b0, rd_last};
    shifted = {rem, dq[TIME_W-1]};
    trial   = {1'b0, shifted} - {2'b00, period};
    qbit    = !trial[PERIOD_W+1];
  end

  // Saturating refill and token take
  always_comb begin
    earned  = (vld && later) ? dq : '0;
    base    = vld ? rd_tok : token_max;
    sum     = {1'b0, base} + {1'b0, earned[TOK_W-1:0]};
    over    = (|earned[TIME_W-1:TOK_W]) || (sum > {1'b0, token_max});
    allow   = (level != '0);
    tok_new = allow ? level - 1'b1 : level;
  end

  // Request context, divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx <= s_tdata[IDX_W-1:0];
      now <= s_tdata[IDX_W +: TIME_W];
      vld <= bucket_valid[s_tdata[IDX_W-1:0]];
    end
    if (cmd.load) begin
      later <= !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
      dq    <= diff[TIME_W-1:0];
      rem   <= '0;
      cnt   <= '0;
    end else if (cmd.step) begin
      rem <= qbit ? trial[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
      dq  <= {dq[TIME_W-2:0], qbit};
      cnt <= cnt + 1'b1;
    end
    if (cmd.clamp) begin
      level <= over ? token_max : sum[TOK_W-1:0];
    end
    if (cmd.finish) begin
      out_allowed <= allow;
      out_tokens  <= tok_new;
      out_created <= !vld;
    end
  end

  assign status.div_last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign status.out_free = !m_tvalid || m_tready;

  assign m_tdata = {{(OUT_DATA_W - TOK_W - 2){1'b0}}, out_created, out_tokens, out_allowed};

endmodule

[rtl/per_client_token_bucket_limiter.sv]
// Top level of the per-client token bucket limiter.
//
//  Port group   Dir  Word contents (lowest bit first)
//  s_*          in   bucket_index[7:0], now_ms[55:8]
//  m_*          out  allowed[0], tokens_left[16:1], bucket_created[17], zero pad
//  cfg_*        in   index 0 token_max (16 b), index 1 refill_period_ms (32 b)
//
// Each request passes from accept through the load of the divider from the
// registered store read, the bit-serial elapsed-time divider, refill and clamp,
// and the store update that loads the result word, then back to idle to take
// the next word; one request is handled at a time.
// The result word sits in an output register; a new request is accepted while
// it waits, and only the store update waits for the register to empty.
// rst is synchronous: it clears all bucket valid marks and config to 10 / 1000.
module per_client_token_bucket_limiter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pctbl_pkg::IN_DATA_W-1:0]  s_tdata,   // bucket_index, now_ms
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pctbl_pkg::OUT_DATA_W-1:0] m_tdata,   // allowed, tokens_left, bucket_created
  input  logic                             cfg_we,
  input  logic [pctbl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pctbl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pctbl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each request
  pctbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, divide, refill and emit
  pctbl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[rtl/pctbl_chk.sv]
// Port-level checker for the token bucket limiter, bound to the top level.
module pctbl_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [pctbl_pkg::OUT_DATA_W-1:0] m_tdata
);
  import pctbl_pkg::*;

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // One request at a time, and no result appears right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
    else $error("request overlap or early result");

  // A refused request leaves an empty bucket
  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[TOK_W:1] == '0)
    else $error("refused with tokens left");

endmodule

bind per_client_token_bucket_limiter pctbl_chk u_chk (.*);

[tb/tb_per_client_token_bucket_limiter.sv]
// Self-checking testbench for the per-client token bucket limiter.
`timescale 1ns / 1ps

module tb_per_client_token_bucket_limiter;
  import pctbl_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 60;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 125;

  // Result word layout, lowest bit first: allowed, tokens_left, bucket_created
  typedef struct packed {
    logic             created;
    logic [TOK_W-1:0] tokens_left;
    logic             allowed;
  } verdict_t;

  // One row of the directed plan: a register write or a request
  typedef struct {
    bit                    is_write;
    logic [CFG_ADDR_W-1:0] reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [IDX_W-1:0]      idx;
    logic [TIME_W-1:0]     now;
    bit                    fixed;
    verdict_t              want;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the limiter: configuration and bucket store
  logic [TOK_W-1:0]    cap    = TOKEN_MAX_RST;
  logic [PERIOD_W-1:0] period = PERIOD_RST;
  bit                  bkt_valid [BUCKETS];
  logic [TOK_W-1:0]    bkt_tokens[BUCKETS];
  logic [TIME_W-1:0]   bkt_stamp [BUCKETS];

  verdict_t  pending_verdicts[$];
  plan_row_t plan[$];
  int        fault_count = 0;
  int        cycle_count = 0;
  bit        quiet       = 1'b0;
  bit        long_hold   = 1'b0;

  per_client_token_bucket_limiter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // bucket_index, now_ms
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // allowed, tokens_left, bucket_created
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Refill the bucket from elapsed time, then try to take one token
  function automatic verdict_t take_token(input logic [IDX_W-1:0] idx,
                                          input logic [TIME_W-1:0] now);
    logic [63:0]       earned;
    logic [63:0]       level;
    logic [TIME_W-1:0] elapsed;
    verdict_t          v;
    v = '0;
    if (!bkt_valid[idx]) begin
      bkt_valid[idx]  = 1'b1;
      bkt_tokens[idx] = cap;
      bkt_stamp[idx]  = now;
      v.created       = 1'b1;
    end
    if (now <= bkt_stamp[idx]) begin
      earned = '0;
    end else if (period == '0) begin
      earned = '1;
    end else begin
      elapsed = now - bkt_stamp[idx];
      earned  = {16'd0, elapsed} / {32'd0, period};
    end
    level = {48'd0, bkt_tokens[idx]};
    // Saturate at capacity; this also clamps a bucket left above a lowered cap
    if (earned > {48'd0, cap} || level + earned > {48'd0, cap}) level = {48'd0, cap};
    else level = level + earned;
    bkt_tokens[idx] = level[TOK_W-1:0];
    if (bkt_tokens[idx] != '0) begin
      bkt_tokens[idx] = bkt_tokens[idx] - 1'b1;
      bkt_stamp[idx]  = now;
      v.allowed       = 1'b1;
    end
    v.tokens_left = bkt_tokens[idx];
    return v;
  endfunction

  function automatic void add_write(input logic [CFG_ADDR_W-1:0] sel,
                                    input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.reg_sel  = sel;
    r.reg_val  = val;
    plan.push_back(r);
  endfunction

  function automatic void add_req(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] now);
    plan_row_t r;
    r = '{default: '0};
    r.idx = idx;
    r.now = now;
    plan.push_back(r);
  endfunction

  function automatic void add_fixed(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] now,
                                    input logic a, input logic [TOK_W-1:0] t, input logic c);
    plan_row_t r;
    r = '{default: '0};
    r.idx   = idx;
    r.now   = now;
    r.fixed = 1'b1;
    r.want  = '{created: c, tokens_left: t, allowed: a};
    plan.push_back(r);
  endfunction

  // Offer one request word and hold it until accepted, then log its verdict
  task automatic send_request(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] now,
                              input bit fixed, input verdict_t want);
    verdict_t v;
    s_tvalid <= 1'b1;
    s_tdata  <= {now, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v = take_token(idx, now);
    pending_verdicts.push_back(fixed ? want : v);
  endtask

  // Random sender gap between words
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Drop valid and wait for the limiter to go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (sel == REG_TOKEN_MAX) cap = val[TOK_W-1:0];
    else if (sel == REG_PERIOD) period = val;
  endtask

  // Directed plan: extremes, partial and backward time, clamping, zero period and cap
  initial begin
    add_fixed(8'd0, 48'd0, 1'b1, 16'd9, 1'b1);
    add_fixed(8'd255, 48'hFFFF_FFFF_FFFF, 1'b1, 16'd9, 1'b1);
    add_req(8'd0, 48'd999);
    add_req(8'd0, 48'd500);
    add_req(8'd0, 48'd3600);
    add_write(REG_TOKEN_MAX, 32'hA5A5_0002);
    add_fixed(8'd2, 48'd7, 1'b1, 16'd1, 1'b1);
    add_fixed(8'd2, 48'd7, 1'b1, 16'd0, 1'b0);
    add_fixed(8'd2, 48'd7, 1'b0, 16'd0, 1'b0);
    add_write(REG_PERIOD, 32'd0);
    add_req(8'd2, 48'd8);
    add_req(8'd2, 48'd8);
    add_fixed(8'd2, 48'd8, 1'b0, 16'd0, 1'b0);
    add_write(REG_TOKEN_MAX, 32'd0);
    add_fixed(8'd3, 48'd20, 1'b0, 16'd0, 1'b1);
    add_fixed(8'd0, 48'd5000, 1'b0, 16'd0, 1'b0);
    add_write(REG_TOKEN_MAX, 32'h0000_FFFF);
    add_write(REG_PERIOD, 32'hFFFF_FFFF);
    add_fixed(8'd4, 48'd1, 1'b1, 16'd65534, 1'b1);
    add_req(8'd4, 48'hFFFF_FFFF_FFFF);
    add_req(8'd255, 48'd0);
    add_write(REG_TOKEN_MAX, 32'd5);
    add_write(REG_PERIOD, 32'd1);
    add_req(8'd4, 48'd0);
    add_req(8'd128, 48'h8000_0000_0000);
    add_req(8'd128, 48'h8000_0000_0003);
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic flag_mismatch(input string what, input logic [TOK_W-1:0] want,
                               input logic [TOK_W-1:0] got);
    fault_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Compare every accepted result word with the oldest pending verdict
  always @(posedge clk) begin : check_results
    verdict_t want;
    verdict_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(verdict_t)-1:0];
      if (pending_verdicts.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.allowed !== want.allowed)
          flag_mismatch("allowed", TOK_W'(want.allowed), TOK_W'(got.allowed));
        if (got.tokens_left !== want.tokens_left)
          flag_mismatch("tokens_left", want.tokens_left, got.tokens_left);
        if (got.created !== want.created)
          flag_mismatch("bucket_created", TOK_W'(want.created), TOK_W'(got.created));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Main sequence
  initial begin : main_flow
    logic [TOK_W-1:0]    new_cap;
    logic [PERIOD_W-1:0] new_period;
    logic [15:0]         junk;
    logic [TIME_W-1:0]   cur;
    logic [TIME_W-1:0]   now;
    logic [63:0]         inc;
    logic [31:0]         scale;
    logic [IDX_W-1:0]    base;
    logic [IDX_W-1:0]    idx;
    int                  pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed plan
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        send_request(plan[i].idx, plan[i].now, plan[i].fixed, plan[i].want);
        sender_gap();
      end
    end

    // Random phases, each under its own register setting
    cur = 48'd10_000;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          new_cap    = 16'hFFFF;
          new_period = 32'hFFFF_FFFF;
        end
        1: begin
          new_cap    = 16'd1;
          new_period = 32'd1;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       new_cap = 16'd1;
            1:       new_cap = 16'd2;
            2:       new_cap = 16'd3;
            3:       new_cap = 16'($urandom_range(4, 20));
            4:       new_cap = 16'($urandom_range(0, 65535));
            default: new_cap = 16'($urandom_range(1, 12));
          endcase
          case ($urandom_range(0, 4))
            0:       new_period = 32'd1;
            1:       new_period = $urandom_range(2, 2000);
            2:       new_period = $urandom();
            3:       new_period = $urandom_range(0, 3);
            default: new_period = $urandom_range(100, 5000);
          endcase
        end
      endcase
      junk = 16'($urandom());
      write_reg(REG_TOKEN_MAX, {junk, new_cap});
      write_reg(REG_PERIOD, new_period);
      if (ph == 2) long_hold = 1'b1;
      if (ph == PHASES - 1) quiet = 1'b1;
      scale = (period == '0) ? 32'd1000 : period;
      base  = 8'($urandom_range(0, 255));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly a small working set of buckets, sometimes any bucket
        if ($urandom_range(0, 99) < 80) idx = base + 8'($urandom_range(0, 5));
        else idx = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          inc = 64'($urandom_range(0, scale / 4));
          cur = cur + inc[TIME_W-1:0];
          now = cur;
        end else if (pick < 75) begin
          inc = 64'($urandom_range(0, scale));
          inc = inc + 64'($urandom_range(0, scale));
          inc = inc + 64'($urandom_range(0, scale));
          cur = cur + inc[TIME_W-1:0];
          now = cur;
        end else if (pick < 85) begin
          inc = 64'($urandom_range(0, scale));
          now = cur - inc[TIME_W-1:0];
        end else if (pick < 92) begin
          now = cur;
        end else begin
          cur = {16'($urandom()), $urandom()};
          now = cur;
        end
        send_request(idx, now, 1'b0, '0);
        sender_gap();
      end
    end

    // Drain and finish
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
